### rtl/caching_buffer_pool_manager_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the caching buffer pool manager
// Implication and invariant checks clocked on i_clk, held off during reset.
// ----------------------------------------------------------------------------
`ifndef CACHING_BUFFER_POOL_MANAGER_UNIT_ASSERT_SVH
`define CACHING_BUFFER_POOL_MANAGER_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define CBPM_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define CBPM_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/cbpm_pkg.sv
// ----------------------------------------------------------------------------
// cbpm_pkg
// Shared constants, types and codes of the caching buffer pool manager.
// ----------------------------------------------------------------------------
package cbpm_pkg;

    localparam int SMALL_ENTRIES = 32;
    localparam int BIG_ENTRIES   = 16;
    localparam int ADDRESS_BITS  = 48;

    localparam int SIZE_W      = 37;
    localparam int PORT_ADDR_W = 48;
    localparam int KIND_W      = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int S_TDATA_W   = 136;

    localparam int SMALL_IW = (SMALL_ENTRIES > 1) ? $clog2(SMALL_ENTRIES) : 1;
    localparam int BIG_IW   = (BIG_ENTRIES > 1) ? $clog2(BIG_ENTRIES) : 1;
    localparam int IDX_W    = (SMALL_IW > BIG_IW) ? SMALL_IW : BIG_IW;
    localparam int KEEP_W   = $clog2(SMALL_ENTRIES + 1);

    typedef logic [SIZE_W-1:0]       t_size;
    typedef logic [ADDRESS_BITS-1:0] t_addr;

    localparam t_size RST_SMALL_LIMIT = t_size'(64'd1048576);
    localparam t_size RST_BIG_SLACK   = t_size'(64'd1048576);
    localparam t_size RST_TRIM_THR    = t_size'(64'd1073741824);

    localparam logic [CFG_IDX_W-1:0] CFG_SMALL_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIG_SLACK   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIM_THR    = 2'd2;

    typedef enum logic [KIND_W-1:0] {
        KIND_HIT      = 4'd0,
        KIND_NEW      = 4'd1,
        KIND_FAIL     = 4'd2,
        KIND_FULL     = 4'd3,
        KIND_TRIM     = 4'd4,
        KIND_RELEASED = 4'd5,
        KIND_EXTERNAL = 4'd6,
        KIND_DOUBLE   = 4'd7,
        KIND_NULL     = 4'd8
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SMALL_SCAN,
        S_BIG_SCAN,
        S_BIG_DONE,
        S_MISS,
        S_TRIM,
        S_TRIM_END,
        S_REL_SMALL,
        S_REL_BIG,
        S_EXT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SMALL_STEP,
        OP_SMALL_HIT,
        OP_BIG_STEP,
        OP_BIG_HIT,
        OP_MISS,
        OP_TRIM_STEP,
        OP_TRIM_END,
        OP_REL_SMALL,
        OP_REL_BIG,
        OP_EMIT_NULL,
        OP_EMIT_EXT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic idx_inc;
        logic idx_clr;
    } t_cmd;

    typedef struct packed {
        logic is_release;
        logic is_big;
        logic rel_zero;
        logic trim_needed;
        logic small_last;
        logic big_last;
        logic small_fit;
        logic small_idle_at;
        logic small_match;
        logic big_match;
        logic best_found;
        logic out_free;
    } t_status;

endpackage

### rtl/caching_buffer_pool_manager_unit.sv
// Sequencing (accept to result valid): allocate walks the small table one entry per cycle
//   and stops at first fit, or does a full 16-entry scan of the big table, then selects or
//   records; release answers address zero without a scan, else trims if needed, then matches.
// Requests: one at a time; the next is taken once the sequencer is back in idle, and a
//   result transfer that waits on the receiver stalls the sequencer.
// Reset: synchronous, active low; clears valid/busy flags, idle byte count and the sequencer.
// ----------------------------------------------------------------------------
// caching_buffer_pool_manager_unit
// Buffer pool manager with small and big cached-entry tables, reuse lookup,
// miss recording, release matching and idle-entry trimming.
// ----------------------------------------------------------------------------
module caching_buffer_pool_manager_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // [36:0] request_size, [84:37] release_address, [132:85] fresh_address,
    // [133] fresh_ok, [135:134] zero
    input  logic [cbpm_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // [0] operation
    input  logic                             i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [47:0] result_address
    output logic [cbpm_pkg::PORT_ADDR_W-1:0] o_m_tdata,
    // [3:0] kind
    output logic [cbpm_pkg::KIND_W-1:0]      o_m_tuser,
    output logic                             o_m_tlast,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [cbpm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [cbpm_pkg::SIZE_W-1:0]      i_cfg_data
);
    import cbpm_pkg::*;

`include "caching_buffer_pool_manager_unit_assert.svh"

    t_cmd    cmd;
    t_status status;
    logic    in_ready;

    assign o_s_tready  = in_ready;
    assign o_cfg_ready = 1'b1;

    cbpm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_status   (status),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    cbpm_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_op     (i_s_tuser),
        .i_in_size   (i_s_tdata[36:0]),
        .i_in_rel    (i_s_tdata[84:37]),
        .i_in_fresh  (i_s_tdata[132:85]),
        .i_in_ok     (i_s_tdata[133]),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_out_kind  (o_m_tuser),
        .o_out_addr  (o_m_tdata),
        .o_out_last  (o_m_tlast)
    );

    `CBPM_ASSERT_NEXT(a_one_at_a_time, i_s_tvalid && o_s_tready, !o_s_tready, "request accepted while busy")
    `CBPM_ASSERT_IMP(a_trim_not_last, o_m_tvalid && o_m_tuser == KIND_TRIM, !o_m_tlast, "trim result marked last")
    `CBPM_ASSERT_IMP(a_null_zero, o_m_tvalid && o_m_tuser == KIND_NULL, o_m_tdata == '0 && o_m_tlast, "null release result malformed")

endmodule

### rtl/cbpm_ctrl.sv
// ----------------------------------------------------------------------------
// cbpm_ctrl
// Sequencer: walks the entry tables one index per cycle, holding in trim while the result
// stage is full, and issues datapath commands for lookup, trim, record and result transfers.
// ----------------------------------------------------------------------------
module cbpm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  cbpm_pkg::t_status i_status,
    output logic             o_in_ready,
    output cbpm_pkg::t_cmd   o_cmd
);
    import cbpm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '{op: OP_NONE, idx_inc: 1'b0, idx_clr: 1'b0};
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op      = OP_LOAD;
                    o_cmd.idx_clr = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!i_status.is_release) begin
                    n_state = i_status.is_big ? S_BIG_SCAN : S_SMALL_SCAN;
                end else if (i_status.rel_zero) begin
                    if (i_status.out_free) begin
                        o_cmd.op = OP_EMIT_NULL;
                        n_state  = S_IDLE;
                    end
                end else if (i_status.trim_needed) begin
                    n_state = S_TRIM;
                end else begin
                    n_state = S_REL_SMALL;
                end
            end
            S_SMALL_SCAN: begin
                if (i_status.small_fit) begin
                    if (i_status.out_free) begin
                        o_cmd.op = OP_SMALL_HIT;
                        n_state  = S_IDLE;
                    end
                end else begin
                    o_cmd.op = OP_SMALL_STEP;
                    if (i_status.small_last) begin
                        n_state = S_MISS;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                    end
                end
            end
            S_BIG_SCAN: begin
                o_cmd.op = OP_BIG_STEP;
                if (i_status.big_last) begin
                    n_state = S_BIG_DONE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_BIG_DONE: begin
                if (i_status.best_found) begin
                    if (i_status.out_free) begin
                        o_cmd.op = OP_BIG_HIT;
                        n_state  = S_IDLE;
                    end
                end else begin
                    n_state = S_MISS;
                end
            end
            S_MISS: begin
                if (i_status.out_free) begin
                    o_cmd.op = OP_MISS;
                    n_state  = S_IDLE;
                end
            end
            S_TRIM: begin
                if (!i_status.small_idle_at || i_status.out_free) begin
                    o_cmd.op = OP_TRIM_STEP;
                    if (i_status.small_last) begin
                        n_state = S_TRIM_END;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                    end
                end
            end
            S_TRIM_END: begin
                o_cmd.op      = OP_TRIM_END;
                o_cmd.idx_clr = 1'b1;
                n_state       = S_REL_SMALL;
            end
            S_REL_SMALL: begin
                if (i_status.small_match) begin
                    if (i_status.out_free) begin
                        o_cmd.op = OP_REL_SMALL;
                        n_state  = S_IDLE;
                    end
                end else if (i_status.small_last) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state       = S_REL_BIG;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_REL_BIG: begin
                if (i_status.big_match) begin
                    if (i_status.out_free) begin
                        o_cmd.op = OP_REL_BIG;
                        n_state  = S_IDLE;
                    end
                end else if (i_status.big_last) begin
                    n_state = S_EXT;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_EXT: begin
                if (i_status.out_free) begin
                    o_cmd.op = OP_EMIT_EXT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/cbpm_dpath.sv
// ----------------------------------------------------------------------------
// cbpm_dpath
// Entry tables, idle byte counter, configuration registers, scan trackers
// and the registered result stage.
// ----------------------------------------------------------------------------
module cbpm_dpath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  cbpm_pkg::t_cmd                   i_cmd,
    output cbpm_pkg::t_status                o_status,
    input  logic                             i_in_op,
    input  logic [cbpm_pkg::SIZE_W-1:0]      i_in_size,
    input  logic [cbpm_pkg::PORT_ADDR_W-1:0] i_in_rel,
    input  logic [cbpm_pkg::PORT_ADDR_W-1:0] i_in_fresh,
    input  logic                             i_in_ok,
    input  logic                             i_cfg_we,
    input  logic [cbpm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [cbpm_pkg::SIZE_W-1:0]      i_cfg_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [cbpm_pkg::KIND_W-1:0]      o_out_kind,
    output logic [cbpm_pkg::PORT_ADDR_W-1:0] o_out_addr,
    output logic                             o_out_last
);
    import cbpm_pkg::*;

    t_size r_small_limit;
    t_size r_big_slack;
    t_size r_trim_thr;

    logic  r_op;
    t_size r_req;
    t_addr r_rel;
    t_addr r_fresh;
    logic  r_ok;

    logic [IDX_W-1:0]  r_idx;
    logic [KEEP_W-1:0] r_keep;
    logic              r_free_found;
    logic [IDX_W-1:0]  r_free_idx;
    logic              r_best_found;
    logic [BIG_IW-1:0] r_best_idx;
    t_size             r_best_size;
    t_size             r_idle;

    t_addr r_s_addr [SMALL_ENTRIES];
    t_size r_s_size [SMALL_ENTRIES];
    logic [SMALL_ENTRIES-1:0] r_s_valid;
    logic [SMALL_ENTRIES-1:0] r_s_busy;
    t_addr r_b_addr [BIG_ENTRIES];
    t_size r_b_size [BIG_ENTRIES];
    logic [BIG_ENTRIES-1:0] r_b_valid;
    logic [BIG_ENTRIES-1:0] r_b_busy;

    logic                      r_out_valid;
    t_kind                     r_out_kind;
    logic [PORT_ADDR_W-1:0]    r_out_addr;
    logic                      r_out_last;

    logic [SMALL_IW-1:0] s_i;
    logic [BIG_IW-1:0]   b_i;
    logic [BIG_IW-1:0]   b_rd;
    logic [SMALL_IW-1:0] keep_i;
    t_addr               s_addr_rd;
    t_size               s_size_rd;
    t_addr               b_addr_rd;
    t_size               b_size_rd;
    t_size               b_diff;
    logic                b_fit;
    logic                b_better;
    logic [SIZE_W:0]     idle_sum;
    t_size               idle_add;
    t_size               idle_sub;
    logic                is_big;
    logic                out_free;
    logic                emit;
    t_kind               emit_kind;
    t_addr               emit_addr;
    logic                emit_last;

    assign s_i       = r_idx[SMALL_IW-1:0];
    assign b_i       = r_idx[BIG_IW-1:0];
    assign keep_i    = r_keep[SMALL_IW-1:0];
    assign b_rd      = (i_cmd.op == OP_BIG_HIT) ? r_best_idx : b_i;
    assign s_addr_rd = r_s_addr[s_i];
    assign s_size_rd = r_s_size[s_i];
    assign b_addr_rd = r_b_addr[b_rd];
    assign b_size_rd = r_b_size[b_rd];
    assign b_diff    = b_size_rd - r_req;
    assign b_fit     = r_b_valid[b_i] && !r_b_busy[b_i] && (b_size_rd >= r_req)
                       && (b_diff < r_big_slack);
    assign b_better  = !r_best_found || (b_size_rd < r_best_size);
    assign idle_sum  = {1'b0, r_idle} + {1'b0, s_size_rd};
    assign idle_add  = idle_sum[SIZE_W] ? '1 : idle_sum[SIZE_W-1:0];
    assign idle_sub  = (r_idle >= s_size_rd) ? (r_idle - s_size_rd) : '0;
    assign is_big    = r_req > r_small_limit;
    assign out_free  = !r_out_valid || i_out_ready;

    assign o_status.is_release    = r_op;
    assign o_status.is_big        = is_big;
    assign o_status.rel_zero      = (r_rel == '0);
    assign o_status.trim_needed   = r_idle > r_trim_thr;
    assign o_status.small_last    = (r_idx == IDX_W'(SMALL_ENTRIES - 1));
    assign o_status.big_last      = (r_idx == IDX_W'(BIG_ENTRIES - 1));
    assign o_status.small_fit     = r_s_valid[s_i] && !r_s_busy[s_i]
                                    && (s_size_rd >= r_req);
    assign o_status.small_idle_at = r_s_valid[s_i] && !r_s_busy[s_i];
    assign o_status.small_match   = r_s_valid[s_i] && (s_addr_rd == r_rel);
    assign o_status.big_match     = r_b_valid[b_i] && (b_addr_rd == r_rel);
    assign o_status.best_found    = r_best_found;
    assign o_status.out_free      = out_free;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_small_limit <= RST_SMALL_LIMIT;
            r_big_slack   <= RST_BIG_SLACK;
            r_trim_thr    <= RST_TRIM_THR;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SMALL_LIMIT: r_small_limit <= i_cfg_data;
                CFG_BIG_SLACK:   r_big_slack   <= i_cfg_data;
                CFG_TRIM_THR:    r_trim_thr    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD) begin
            r_op    <= i_in_op;
            r_req   <= i_in_size;
            r_rel   <= t_addr'(i_in_rel);
            r_fresh <= t_addr'(i_in_fresh);
            r_ok    <= i_in_ok;
        end
    end

    // scan trackers and counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx        <= '0;
            r_keep       <= '0;
            r_free_found <= 1'b0;
            r_best_found <= 1'b0;
            r_idle       <= '0;
        end else begin
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
            case (i_cmd.op)
                OP_LOAD: begin
                    r_keep       <= '0;
                    r_free_found <= 1'b0;
                    r_best_found <= 1'b0;
                end
                OP_SMALL_STEP: begin
                    if (!r_s_valid[s_i] && !r_free_found) begin
                        r_free_found <= 1'b1;
                        r_free_idx   <= r_idx;
                    end
                end
                OP_BIG_STEP: begin
                    if (!r_b_valid[b_i] && !r_free_found) begin
                        r_free_found <= 1'b1;
                        r_free_idx   <= r_idx;
                    end
                    if (b_fit && b_better) begin
                        r_best_found <= 1'b1;
                        r_best_idx   <= b_i;
                        r_best_size  <= b_size_rd;
                    end
                end
                OP_SMALL_HIT: begin
                    r_idle <= idle_sub;
                end
                OP_TRIM_STEP: begin
                    if (r_s_valid[s_i] && r_s_busy[s_i]) begin
                        r_keep <= r_keep + 1'b1;
                    end
                end
                OP_TRIM_END: begin
                    r_idle <= '0;
                end
                OP_REL_SMALL: begin
                    if (r_s_busy[s_i]) begin
                        r_idle <= idle_add;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // entry flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= '0;
            r_s_busy  <= '0;
            r_b_valid <= '0;
            r_b_busy  <= '0;
        end else begin
            case (i_cmd.op)
                OP_SMALL_HIT: r_s_busy[s_i] <= 1'b1;
                OP_BIG_HIT:   r_b_busy[r_best_idx] <= 1'b1;
                OP_MISS: begin
                    if (r_ok && r_free_found) begin
                        if (is_big) begin
                            r_b_valid[r_free_idx[BIG_IW-1:0]] <= 1'b1;
                            r_b_busy[r_free_idx[BIG_IW-1:0]]  <= 1'b1;
                        end else begin
                            r_s_valid[r_free_idx[SMALL_IW-1:0]] <= 1'b1;
                            r_s_busy[r_free_idx[SMALL_IW-1:0]]  <= 1'b1;
                        end
                    end
                end
                OP_TRIM_STEP: begin
                    if (r_s_valid[s_i] && r_s_busy[s_i]) begin
                        r_s_valid[keep_i] <= 1'b1;
                        r_s_busy[keep_i]  <= 1'b1;
                    end
                end
                OP_TRIM_END: begin
                    for (int j = 0; j < SMALL_ENTRIES; j++) begin
                        if (KEEP_W'(j) >= r_keep) begin
                            r_s_valid[j] <= 1'b0;
                            r_s_busy[j]  <= 1'b0;
                        end
                    end
                end
                OP_REL_SMALL: r_s_busy[s_i] <= 1'b0;
                OP_REL_BIG:   r_b_busy[b_i] <= 1'b0;
                default: begin
                end
            endcase
        end
    end

    // entry contents
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_MISS && r_ok && r_free_found) begin
            if (is_big) begin
                r_b_addr[r_free_idx[BIG_IW-1:0]] <= r_fresh;
                r_b_size[r_free_idx[BIG_IW-1:0]] <= r_req;
            end else begin
                r_s_addr[r_free_idx[SMALL_IW-1:0]] <= r_fresh;
                r_s_size[r_free_idx[SMALL_IW-1:0]] <= r_req;
            end
        end else if (i_cmd.op == OP_TRIM_STEP && r_s_valid[s_i] && r_s_busy[s_i]) begin
            r_s_addr[keep_i] <= s_addr_rd;
            r_s_size[keep_i] <= s_size_rd;
        end
    end

    // result selection
    always_comb begin
        emit      = 1'b0;
        emit_kind = KIND_HIT;
        emit_addr = '0;
        emit_last = 1'b1;
        case (i_cmd.op)
            OP_SMALL_HIT: begin
                emit      = 1'b1;
                emit_addr = s_addr_rd;
            end
            OP_BIG_HIT: begin
                emit      = 1'b1;
                emit_addr = b_addr_rd;
            end
            OP_MISS: begin
                emit = 1'b1;
                if (!r_ok) begin
                    emit_kind = KIND_FAIL;
                end else if (r_free_found) begin
                    emit_kind = KIND_NEW;
                    emit_addr = r_fresh;
                end else begin
                    emit_kind = KIND_FULL;
                    emit_addr = r_fresh;
                end
            end
            OP_TRIM_STEP: begin
                emit      = r_s_valid[s_i] && !r_s_busy[s_i];
                emit_kind = KIND_TRIM;
                emit_addr = s_addr_rd;
                emit_last = 1'b0;
            end
            OP_REL_SMALL: begin
                emit      = 1'b1;
                emit_kind = r_s_busy[s_i] ? KIND_RELEASED : KIND_DOUBLE;
                emit_addr = r_rel;
            end
            OP_REL_BIG: begin
                emit      = 1'b1;
                emit_kind = r_b_busy[b_i] ? KIND_RELEASED : KIND_DOUBLE;
                emit_addr = r_rel;
            end
            OP_EMIT_NULL: begin
                emit      = 1'b1;
                emit_kind = KIND_NULL;
            end
            OP_EMIT_EXT: begin
                emit      = 1'b1;
                emit_kind = KIND_EXTERNAL;
                emit_addr = r_rel;
            end
            default: begin
            end
        endcase
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_kind <= emit_kind;
            r_out_addr <= PORT_ADDR_W'(emit_addr);
            r_out_last <= emit_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_addr  = r_out_addr;
    assign o_out_last  = r_out_last;

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the caching buffer pool manager: random and directed
// allocate/release transfers, a behavioral predictor, in-order result checks.
// ----------------------------------------------------------------------------
module testbench;
    import cbpm_pkg::*;

    typedef struct packed {
        logic  op;
        t_size size;
        t_addr rel_addr;
        t_addr fresh;
        logic  ok;
    } t_req;

    typedef struct packed {
        t_kind kind;
        t_addr addr;
        logic  last;
    } t_res;

    logic i_clk = 0, i_rst_n = 0;
    logic i_s_tvalid = 0, i_m_tready = 0, i_cfg_valid = 0;
    logic [S_TDATA_W-1:0] i_s_tdata = '0;
    logic i_s_tuser = 0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [SIZE_W-1:0] i_cfg_data = '0;
    logic o_s_tready, o_m_tvalid, o_m_tlast, o_cfg_ready;
    logic [PORT_ADDR_W-1:0] o_m_tdata;
    logic [KIND_W-1:0] o_m_tuser;

    caching_buffer_pool_manager_unit dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // predictor state
    t_addr sm_addr [SMALL_ENTRIES];
    t_size sm_size [SMALL_ENTRIES];
    logic  sm_val  [SMALL_ENTRIES];
    logic  sm_busy [SMALL_ENTRIES];
    t_addr bg_addr [BIG_ENTRIES];
    t_size bg_size [BIG_ENTRIES];
    logic  bg_val  [BIG_ENTRIES];
    logic  bg_busy [BIG_ENTRIES];
    t_size idle_bytes;
    t_size lim_small, slack_big, thr_trim;

    t_req pending_reqs[$];
    t_res expected_results[$];
    t_addr known_addrs[$];
    int errors = 0, n_results = 0, n_reqs = 0;
    int send_idle = 36, recv_idle = 82;
    logic hold_recv = 0;
    logic hold_go = 0;

    function automatic void push_result(t_kind k, t_addr a);
        t_res r;
        r.kind = k; r.addr = a; r.last = 0;
        expected_results.insert(expected_results.size(), r);
    endfunction

    function automatic void record_miss(logic big, t_size sz, t_addr fr, logic ok);
        if (!ok) begin
            push_result(KIND_FAIL, '0);
            return;
        end
        if (big) begin
            for (int i = 0; i < BIG_ENTRIES; i++)
                if (!bg_val[i]) begin
                    bg_addr[i] = fr; bg_size[i] = sz; bg_val[i] = 1; bg_busy[i] = 1;
                    push_result(KIND_NEW, fr);
                    return;
                end
        end else begin
            for (int i = 0; i < SMALL_ENTRIES; i++)
                if (!sm_val[i]) begin
                    sm_addr[i] = fr; sm_size[i] = sz; sm_val[i] = 1; sm_busy[i] = 1;
                    push_result(KIND_NEW, fr);
                    return;
                end
        end
        push_result(KIND_FULL, fr);
    endfunction

    function automatic void predict_pool(t_req q);
        int sel, keep;
        if (!q.op) begin
            if (q.size > lim_small) begin
                sel = -1;
                for (int i = 0; i < BIG_ENTRIES; i++)
                    if (bg_val[i] && !bg_busy[i] && bg_size[i] >= q.size &&
                        bg_size[i] - q.size < slack_big)
                        if (sel < 0 || bg_size[i] < bg_size[sel]) sel = i;
                if (sel >= 0) begin
                    bg_busy[sel] = 1;
                    push_result(KIND_HIT, bg_addr[sel]);
                end else record_miss(1, q.size, q.fresh, q.ok);
            end else begin
                sel = -1;
                for (int i = 0; i < SMALL_ENTRIES; i++)
                    if (sel < 0 && sm_val[i] && !sm_busy[i] && sm_size[i] >= q.size)
                        sel = i;
                if (sel >= 0) begin
                    sm_busy[sel] = 1;
                    idle_bytes = (idle_bytes >= sm_size[sel]) ? idle_bytes - sm_size[sel] : '0;
                    push_result(KIND_HIT, sm_addr[sel]);
                end else record_miss(0, q.size, q.fresh, q.ok);
            end
        end else if (q.rel_addr == '0) begin
            push_result(KIND_NULL, '0);
        end else begin
            if (idle_bytes > thr_trim) begin
                keep = 0;
                for (int i = 0; i < SMALL_ENTRIES; i++) begin
                    if (!sm_val[i]) continue;
                    if (!sm_busy[i]) push_result(KIND_TRIM, sm_addr[i]);
                    else begin
                        sm_addr[keep] = sm_addr[i]; sm_size[keep] = sm_size[i];
                        sm_val[keep] = 1; sm_busy[keep] = 1;
                        keep++;
                    end
                end
                for (int i = keep; i < SMALL_ENTRIES; i++) begin
                    sm_val[i] = 0; sm_busy[i] = 0;
                end
                idle_bytes = '0;
            end
            sel = -1;
            for (int i = 0; i < SMALL_ENTRIES; i++)
                if (sel < 0 && sm_val[i] && sm_addr[i] == q.rel_addr) sel = i;
            if (sel >= 0) begin
                if (sm_busy[sel]) begin
                    sm_busy[sel] = 0;
                    idle_bytes = ({1'b0, idle_bytes} + sm_size[sel] > {1'b0, {SIZE_W{1'b1}}})
                        ? {SIZE_W{1'b1}} : idle_bytes + sm_size[sel];
                    push_result(KIND_RELEASED, q.rel_addr);
                end else push_result(KIND_DOUBLE, q.rel_addr);
            end else begin
                for (int i = 0; i < BIG_ENTRIES; i++)
                    if (sel < 0 && bg_val[i] && bg_addr[i] == q.rel_addr) sel = i;
                if (sel >= 0) begin
                    if (bg_busy[sel]) begin
                        bg_busy[sel] = 0;
                        push_result(KIND_RELEASED, q.rel_addr);
                    end else push_result(KIND_DOUBLE, q.rel_addr);
                end else push_result(KIND_EXTERNAL, q.rel_addr);
            end
        end
        expected_results[$].last = 1;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                predict_pool(pending_reqs.pop_front());
                n_reqs++;
            end
            if ((!i_s_tvalid || o_s_tready) && pending_reqs.size() > 0 &&
                    $urandom_range(99) >= send_idle) begin
                i_s_tvalid <= 1;
                i_s_tdata <= {2'b0, pending_reqs[0].ok, pending_reqs[0].fresh,
                              pending_reqs[0].rel_addr, pending_reqs[0].size};
                i_s_tuser <= pending_reqs[0].op;
            end else if (o_s_tready) begin
                i_s_tvalid <= 0;
            end
            i_m_tready <= !hold_recv && $urandom_range(99) >= recv_idle;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            n_results++;
            if (expected_results.size() == 0) begin
                $error("unexpected result kind=%0d addr=%h", o_m_tuser, o_m_tdata);
                errors++;
            end else begin
                e = expected_results.pop_front();
                if (o_m_tuser !== e.kind) begin
                    $error("kind exp %0d got %0d", e.kind, o_m_tuser); errors++;
                end
                if (o_m_tdata !== e.addr) begin
                    $error("result_address exp %h got %h", e.addr, o_m_tdata); errors++;
                end
                if (o_m_tlast !== e.last) begin
                    $error("last exp %0d got %0d", e.last, o_m_tlast); errors++;
                end
            end
        end
    end

    // long receiver stall
    initial begin
        wait (hold_go);
        hold_recv <= 1;
        repeat (300) @(posedge i_clk);
        hold_recv <= 0;
    end

    task automatic drain();
        wait (pending_reqs.size() == 0 && !i_s_tvalid);
        wait (expected_results.size() == 0);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, t_size val);
        @(posedge i_clk);
        i_cfg_valid <= 1; i_cfg_index <= idx; i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        if (idx == CFG_SMALL_LIMIT) lim_small = val;
        else if (idx == CFG_BIG_SLACK) slack_big = val;
        else thr_trim = val;
    endtask

    function automatic t_addr pick_addr();
        t_addr a;
        a = t_addr'({$urandom, $urandom});
        if (a == '0) a = 48'h1000;
        known_addrs.insert(known_addrs.size(), a);
        return a;
    endfunction

    function automatic void add_alloc(t_size sz, logic ok);
        t_req q;
        q = '0; q.op = 0; q.size = sz; q.fresh = pick_addr(); q.ok = ok;
        pending_reqs.insert(pending_reqs.size(), q);
    endfunction

    function automatic void add_release(t_addr a);
        t_req q;
        q = '0; q.op = 1; q.rel_addr = a;
        q.size = t_size'({$urandom, $urandom});
        q.fresh = t_addr'({$urandom, $urandom});
        q.ok = 1'($urandom);
        pending_reqs.insert(pending_reqs.size(), q);
    endfunction

    function automatic void add_random(int n);
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(9))
                0, 1, 2: add_alloc(t_size'($urandom_range(4096)), $urandom_range(9) != 0);
                3: add_alloc(lim_small + t_size'($urandom_range(4096)),
                             $urandom_range(9) != 0);
                4: add_alloc(t_size'({$urandom, $urandom}), 1'($urandom));
                5: add_release(t_addr'({$urandom, $urandom}));
                6: add_release('0);
                default: add_release(known_addrs.size() > 0 ?
                    known_addrs[$urandom_range(known_addrs.size() - 1)] : t_addr'(1));
            endcase
        end
    endfunction

    initial begin
        for (int i = 0; i < SMALL_ENTRIES; i++) begin sm_val[i] = 0; sm_busy[i] = 0; end
        for (int i = 0; i < BIG_ENTRIES; i++) begin bg_val[i] = 0; bg_busy[i] = 0; end
        idle_bytes = '0;
        lim_small = RST_SMALL_LIMIT; slack_big = RST_BIG_SLACK; thr_trim = RST_TRIM_THR;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: reset settings
        add_alloc(0, 1);
        add_alloc(t_size'(RST_SMALL_LIMIT), 1);
        add_alloc(t_size'(RST_SMALL_LIMIT) + 1, 1);
        add_alloc({SIZE_W{1'b1}}, 0);
        pending_reqs.insert(pending_reqs.size(),
            '{op: 0, size: 100, rel_addr: '0, fresh: '0, ok: 1});
        add_release(known_addrs[0]);
        add_release(known_addrs[0]);
        add_release(known_addrs[2]);
        add_alloc(t_size'(RST_SMALL_LIMIT) + 1, 1);
        add_release('0);
        add_release('0);
        add_release({PORT_ADDR_W{1'b1}});
        add_alloc(0, 1);
        drain();

        // small trim threshold, tiny slack; fill the big table
        write_reg(CFG_SMALL_LIMIT, 64);
        write_reg(CFG_BIG_SLACK, 0);
        write_reg(CFG_TRIM_THR, 0);
        for (int k = 0; k < 18; k++) add_alloc(t_size'(65 + k), 1);
        for (int k = 0; k < 4; k++) add_alloc(8, 1);
        add_release(known_addrs[known_addrs.size() - 1]);
        add_release(known_addrs[known_addrs.size() - 2]);
        add_release(known_addrs[known_addrs.size() - 3]);
        hold_go = 1;
        drain();

        // random phases: sender light idling, then swapped, then none
        write_reg(CFG_SMALL_LIMIT, {SIZE_W{1'b1}});
        write_reg(CFG_BIG_SLACK, {SIZE_W{1'b1}});
        write_reg(CFG_TRIM_THR, {SIZE_W{1'b1}});
        add_random(20);
        drain();
        send_idle = 82; recv_idle = 36;
        write_reg(CFG_SMALL_LIMIT, 2048);
        write_reg(CFG_BIG_SLACK, 8192);
        write_reg(CFG_TRIM_THR, 6000);
        add_random(25);
        drain();
        send_idle = 0; recv_idle = 0;
        write_reg(CFG_SMALL_LIMIT, 0);
        write_reg(CFG_TRIM_THR, 1);
        add_random(25);
        drain();

        $display("covered %0d requests and %0d results over five register settings",
                 n_reqs, n_results);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end
endmodule
